@@ design/sliding_window_first_negative_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window first negative block.
// Each macro samples on the rising edge of clk_i and is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_FIRST_NEGATIVE_MACROS_SVH
`define SLIDING_WINDOW_FIRST_NEGATIVE_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define SWFN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SWFN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/swfn_pkg.sv @@
// ----------------------------------------------------------------------------
// swfn_pkg
// Shared constants and types of the sliding window first negative block.
// ----------------------------------------------------------------------------
`default_nettype none

package swfn_pkg;

  // Queue depth and sample width.
  localparam int MaxWindow  = 256;
  localparam int SampleBits = 32;

  // Ring pointer, fill count and position widths.
  localparam int PtrW = $clog2(MaxWindow);
  localparam int CntW = PtrW + 1;
  localparam int PosW = PtrW + 1;

  // Width of the window size register.
  localparam int WinCfgW = 9;

  // One queued negative sample and its position.
  typedef struct packed {
    logic signed [SampleBits-1:0] value;
    logic [PosW-1:0]              pos;
  } entry_t;

  // Write request into the ring storage.
  typedef struct packed {
    logic            en;
    logic [PtrW-1:0] addr;
    entry_t          entry;
  } wr_req_t;

  // One result word.
  typedef struct packed {
    logic signed [SampleBits-1:0] first_negative;
    logic                         last_window;
  } result_t;

endpackage

`default_nettype wire

@@ design/swfn_intf.sv @@
// ----------------------------------------------------------------------------
// swfn channel interfaces
// Valid/ready channels for samples, results and the window size register.
// ----------------------------------------------------------------------------
`default_nettype none

// Sample channel.
interface swfn_in_if import swfn_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         end_of_sequence;

  modport source (output valid, output sample, output end_of_sequence, input ready);
  modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

// Result channel.
interface swfn_out_if import swfn_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] first_negative;
  logic                         last_window;

  modport source (output valid, output first_negative, output last_window, input ready);
  modport sink   (input valid, input first_negative, input last_window, output ready);
endinterface

// Window size register write channel.
interface swfn_cfg_if import swfn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WinCfgW-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

@@ design/swfn_ring.sv @@
// ----------------------------------------------------------------------------
// swfn_ring
// Ring storage of queued negative samples: one write port, one registered
// read port, with write-to-read forwarding for same-cycle accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module swfn_ring import swfn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wr_req_t         wr_i,
  input  logic [PtrW-1:0] rd_addr_i,
  output entry_t          rd_o
);

  entry_t mem [MaxWindow];
  entry_t rd_q;
  entry_t fwd_data_q;
  logic   fwd_q;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    rd_q       <= mem[rd_addr_i];
    fwd_data_q <= wr_i.entry;
  end

  // A write to the address being read wins over the old memory contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= wr_i.en && (wr_i.addr == rd_addr_i);
    end
  end

  assign rd_o = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

@@ design/sliding_window_first_negative.sv @@
// ----------------------------------------------------------------------------
// sliding_window_first_negative
// Reports the oldest negative sample of each sliding window of a sequence.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                          Word accepted when
//  in_i     in         sample, end_of_sequence          valid && ready
//  out_o    out        first_negative, last_window      valid && ready
//  cfg_i    in         window_size                      valid && ready
//
// One sample is taken every cycle while the skid word is empty; once the
// window has filled, its result goes to out_o through the output stage. The
// front queue entry sits in a register, the entry behind it is read from
// the ring every cycle. A two-word output stage lets input continue while
// one result waits. Reset clears pointers and counters at once, not the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_first_negative import swfn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  swfn_cfg_if.sink     cfg_i,
  swfn_in_if.sink      in_i,
  swfn_out_if.source   out_o
);

  `include "sliding_window_first_negative_macros.svh"

  logic [WinCfgW-1:0] win_q;
  logic [PosW-1:0]    eff_win;

  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            filled_q, filled_d;
  entry_t          front_q, front_d;

  logic            accept;
  logic [PosW-1:0] age;
  logic            pop;
  logic            push;
  logic [CntW-1:0] cnt_pop;
  logic [CntW-1:0] cnt_push;
  logic [PosW:0]   pos_inc;
  logic            filled_set;
  logic            produce;
  entry_t          new_entry;
  entry_t          second;
  wr_req_t         wr_req;
  logic [PtrW-1:0] rd_addr;
  logic [PtrW-1:0] ptr_sum;
  result_t         result;

  result_t         main_q, skid_q;
  logic            main_v_q, skid_v_q;
  logic            take;

  // Window size register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WinCfgW'(1);
    end else if (cfg_i.valid) begin
      win_q <= cfg_i.window_size;
    end
  end

  // A zero size acts as one, a size above the depth saturates.
  always_comb begin
    if (win_q == '0) begin
      eff_win = PosW'(1);
    end else if (int'(win_q) > MaxWindow) begin
      eff_win = PosW'(MaxWindow);
    end else begin
      eff_win = PosW'(win_q);
    end
  end

  // Pop and push decisions.
  assign accept    = in_i.valid && in_i.ready;
  assign age       = pos_q - front_q.pos;
  assign pop       = accept && (count_q != '0) && (age >= eff_win);
  assign cnt_pop   = count_q - CntW'(pop);
  assign push      = accept && in_i.sample[SampleBits-1] && (cnt_pop != CntW'(MaxWindow));
  assign cnt_push  = cnt_pop + CntW'(push);
  assign new_entry = '{value: in_i.sample, pos: pos_q};

  // Front entry after this word: the one behind it, the new sample or unchanged.
  always_comb begin
    if (pop && (cnt_pop != '0)) begin
      front_d = second;
    end else if ((cnt_pop == '0) && push) begin
      front_d = new_entry;
    end else begin
      front_d = front_q;
    end
  end

  // Window fill and result.
  assign pos_inc    = {1'b0, pos_q} + (PosW+1)'(1);
  assign filled_set = pos_inc >= {1'b0, eff_win};
  assign produce    = accept && (filled_q || filled_set);
  assign result     = '{first_negative: (cnt_push != '0) ? front_d.value : '0,
                        last_window:    in_i.end_of_sequence};

  // Pointer and counter updates; the end of a sequence clears them.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    pos_d    = pos_q;
    filled_d = filled_q;
    if (accept) begin
      if (in_i.end_of_sequence) begin
        head_d   = '0;
        tail_d   = '0;
        count_d  = '0;
        pos_d    = '0;
        filled_d = 1'b0;
      end else begin
        head_d   = head_q + PtrW'(pop);
        tail_d   = tail_q + PtrW'(push);
        count_d  = cnt_push;
        pos_d    = pos_inc[PosW-1:0];
        filled_d = filled_q || filled_set;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      pos_q    <= '0;
      filled_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  // Ring storage: every negative goes in at the tail while there is room, the
  // entry behind the next front is fetched every cycle.
  assign wr_req  = '{en: push, addr: tail_q, entry: new_entry};
  assign rd_addr = head_d + PtrW'(1);

  swfn_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr_req),
    .rd_addr_i (rd_addr),
    .rd_o      (second)
  );

  // Output stage with a skid word.
  assign take        = main_v_q && out_o.ready;
  assign in_i.ready  = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (produce) begin
      if (!main_v_q || take) begin
        main_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      if (!main_v_q || take) begin
        main_q <= result;
      end else begin
        skid_q <= result;
      end
    end else if (take && skid_v_q) begin
      main_q <= skid_q;
    end
  end

  assign out_o.valid          = main_v_q;
  assign out_o.first_negative = main_q.first_negative;
  assign out_o.last_window    = main_q.last_window;

  // Checks on queue bookkeeping and the output stage.
  assign ptr_sum = head_q + count_q[PtrW-1:0];

  `SWFN_ASSERT(a_count_bound, count_q <= CntW'(MaxWindow), "queue fill above depth")
  `SWFN_ASSERT(a_ring_ptrs, ptr_sum == tail_q, "tail does not match head plus fill")
  `SWFN_ASSERT(a_skid_order, !skid_v_q || main_v_q, "skid word held without main word")
  `SWFN_ASSERT_NEXT(a_seq_clear, accept && in_i.end_of_sequence,
                    (count_q == '0) && (pos_q == '0) && !filled_q, "sequence state not cleared")

endmodule

`default_nettype wire

@@ sim/tb_sliding_window_first_negative.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_window_first_negative
// Self-checking bench for the sliding window first negative block. Samples
// are sent over the input channel with random gaps, and a local model of the
// negative sample queue predicts each result word. Results are taken with
// random back-pressure and compared field by field in arrival order. Window
// size writes happen only while the block is idle, some of them in the
// middle of a sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_window_first_negative;
  import swfn_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 10;
  localparam int SettleCycles = 4;
  localparam int RandomItems  = 1100;
  localparam int MaxReports   = 10;

  logic clk;
  logic rst_n;

  // When set, neither side inserts idle cycles.
  bit steady;

  swfn_cfg_if window_if ();
  swfn_in_if  sample_if ();
  swfn_out_if result_if ();

  sliding_window_first_negative i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (window_if),
    .in_i   (sample_if),
    .out_o  (result_if)
  );

  // Local copy of the window register and the negative sample queue.
  logic [WinCfgW-1:0]           window_reg;
  logic signed [SampleBits-1:0] neg_value_ring [MaxWindow];
  logic [PosW-1:0]              neg_pos_ring   [MaxWindow];
  logic [PtrW-1:0]              ring_head;
  logic [PtrW-1:0]              ring_tail;
  int                           ring_fill;
  logic [PosW-1:0]              next_position;
  bit                           window_full;

  // Result words still owed by the block, oldest first.
  result_t expected_results [$];

  int items_sent;
  int results_checked;
  int window_writes;
  int mismatch_count;
  int unexpected_count;
  int report_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("Run limit reached with %0d result words outstanding.",
             expected_results.size());
    $display("status: fail");
    $finish;
  end

  // Result side back-pressure, changed at the falling edge.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_if.ready = steady || ($urandom_range(99) >= 8);
    end
  end

  // Clear the per-sequence part of the local queue.
  function automatic void clear_sequence();
    ring_head     = '0;
    ring_tail     = '0;
    ring_fill     = 0;
    next_position = '0;
    window_full   = 1'b0;
  endfunction

  // Window length the block actually uses for a register value.
  function automatic int effective_window(input logic [WinCfgW-1:0] size);
    if (size == '0) begin
      return 1;
    end
    if (int'(size) > MaxWindow) begin
      return MaxWindow;
    end
    return int'(size);
  endfunction

  // Advance the local queue by one accepted sample and queue its result word.
  task automatic predict_first_negative(input logic signed [SampleBits-1:0] smp,
                                        input logic eos);
    int              eff;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] age;
    result_t         res;
    eff = effective_window(window_reg);
    pos = next_position;
    // Drop the front entry once it is older than the window.
    if (ring_fill > 0) begin
      age = pos - neg_pos_ring[ring_head];
      if (int'(age) >= eff) begin
        ring_head = ring_head + PtrW'(1);
        ring_fill--;
      end
    end
    // Queue a negative sample while there is room.
    if (smp[SampleBits-1] && ring_fill < MaxWindow) begin
      neg_value_ring[ring_tail] = smp;
      neg_pos_ring[ring_tail]   = pos;
      ring_tail = ring_tail + PtrW'(1);
      ring_fill++;
    end
    if (int'(pos) + 1 >= eff) begin
      window_full = 1'b1;
    end
    if (window_full) begin
      res.first_negative = (ring_fill > 0) ? neg_value_ring[ring_head] : '0;
      res.last_window    = eos;
      expected_results.insert(expected_results.size(), res);
    end
    next_position = pos + PosW'(1);
    if (eos) begin
      clear_sequence();
    end
  endtask

  // Present one sample word, hold it until accepted, then predict its result.
  task automatic send_sample(input logic signed [SampleBits-1:0] smp,
                             input logic eos);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 8) begin
      sample_if.valid = 1'b0;
      @(negedge clk);
    end
    sample_if.valid           = 1'b1;
    sample_if.sample          = smp;
    sample_if.end_of_sequence = eos;
    do begin
      @(posedge clk);
    end while (!sample_if.ready);
    predict_first_negative(smp, eos);
    items_sent++;
  endtask

  // Stop sending and wait until every owed result word has arrived.
  task automatic drain_results();
    @(negedge clk);
    sample_if.valid = 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    // A last sample that causes no result may still be in flight.
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write the window size register while the block is idle.
  task automatic write_window(input logic [WinCfgW-1:0] size);
    drain_results();
    @(negedge clk);
    window_if.valid       = 1'b1;
    window_if.window_size = size;
    do begin
      @(posedge clk);
    end while (!window_if.ready);
    window_reg = size;
    window_writes++;
    @(negedge clk);
    window_if.valid = 1'b0;
  endtask

  // Random sample: negative with the given percentage, extremes now and then.
  function automatic logic signed [SampleBits-1:0] random_sample(input int neg_pct);
    logic [SampleBits-1:0] raw;
    raw = $urandom;
    case ($urandom_range(19))
      0: return {1'b1, {(SampleBits - 1){1'b0}}};
      1: return {1'b0, {(SampleBits - 1){1'b1}}};
      2: return '0;
      3: return '1;
      default: begin
        raw[SampleBits-1] = ($urandom_range(99) < neg_pct);
        return raw;
      end
    endcase
  endfunction

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        unexpected_count++;
        if (report_count < MaxReports) begin
          $display("Unexpected result word: first_negative %0d last_window %0b",
                   result_if.first_negative, result_if.last_window);
        end
        report_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (result_if.first_negative !== want.first_negative) begin
          mismatch_count++;
          if (report_count < MaxReports) begin
            $display("Result %0d first_negative: expected %0d, got %0d",
                     results_checked, want.first_negative, result_if.first_negative);
          end
          report_count++;
        end
        if (result_if.last_window !== want.last_window) begin
          mismatch_count++;
          if (report_count < MaxReports) begin
            $display("Result %0d last_window: expected %0b, got %0b",
                     results_checked, want.last_window, result_if.last_window);
          end
          report_count++;
        end
      end
    end
  end

  // Default window of one right after reset, with the most negative sample value.
  task automatic test_reset_default();
    send_sample(-32'sd5, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample({1'b1, {(SampleBits - 1){1'b0}}}, 1'b0);
    send_sample(-32'sd1, 1'b1);
  endtask

  // Field extremes in a window of three, including a window with no negative.
  task automatic test_field_extremes();
    write_window(9'd3);
    send_sample({1'b1, {(SampleBits - 1){1'b0}}}, 1'b0);
    send_sample({1'b0, {(SampleBits - 1){1'b1}}}, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b1);
  endtask

  // A zero window behaves as one; sizes above the queue depth are then written.
  task automatic test_window_limits();
    write_window(9'd0);
    send_sample(-32'sd9, 1'b0);
    send_sample(32'sd4, 1'b0);
    send_sample(-32'sd2, 1'b1);
    write_window(9'd511);
    write_window(9'd257);
  endtask

  // A sequence shorter than the window gives no result at all.
  task automatic test_short_sequence();
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd8, 1'b0);
    send_sample(-32'sd4, 1'b0);
    send_sample(32'sd6, 1'b1);
  endtask

  // Shrink the window in the middle of a sequence with a backlog queued.
  task automatic test_window_change();
    write_window(9'd4);
    send_sample(-32'sd10, 1'b0);
    send_sample(-32'sd11, 1'b0);
    send_sample(-32'sd12, 1'b0);
    send_sample(32'sd13, 1'b0);
    write_window(9'd1);
    send_sample(32'sd14, 1'b0);
    send_sample(-32'sd15, 1'b0);
    send_sample(32'sd16, 1'b1);
  endtask

  // Random phases: a window setting, then mostly complete sequences.
  task automatic test_random_streams();
    int               sent;
    int               phase;
    int               eff;
    int               neg_pct;
    int               n_seq;
    int               len;
    bit               open_end;
    logic [WinCfgW-1:0] size;
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(11))
        0: size = 9'd1;
        1: size = 9'd0;
        2: size = (sent < RandomItems - 400) ? 9'd256 : 9'd2;
        3: size = (sent < RandomItems - 400) ? 9'($urandom_range(257, 511)) : 9'd511;
        4: size = 9'($urandom_range(13, 40));
        default: size = 9'($urandom_range(2, 12));
      endcase
      // Saturated sizes are used only early in the run; late in the run they become three.
      if (size == 9'd511 && sent >= RandomItems - 400) begin
        size = 9'd3;
      end
      // A run of several phases goes without any idle cycle.
      steady = (phase >= 3) && (phase < 8);
      write_window(size);
      eff     = effective_window(size);
      neg_pct = $urandom_range(0, 100);
      n_seq   = (eff > 40) ? 1 : $urandom_range(2, 6);
      for (int s = 0; s < n_seq; s++) begin
        if ($urandom_range(5) == 0) begin
          len = $urandom_range(1, eff);
        end else begin
          len = eff + $urandom_range(0, 20);
        end
        // The last sequence of a phase is sometimes left open across a rewrite.
        open_end = (s == n_seq - 1) && ($urandom_range(2) == 0);
        for (int k = 0; k < len; k++) begin
          send_sample(random_sample(neg_pct), (k == len - 1) && !open_end);
          sent++;
        end
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // Main sequence.
  initial begin
    rst_n                     = 1'b0;
    steady                    = 1'b0;
    sample_if.valid           = 1'b0;
    sample_if.sample          = '0;
    sample_if.end_of_sequence = 1'b0;
    window_if.valid           = 1'b0;
    window_if.window_size     = '0;
    window_reg                = 9'd1;
    items_sent                = 0;
    results_checked           = 0;
    window_writes             = 0;
    mismatch_count            = 0;
    unexpected_count          = 0;
    report_count              = 0;
    clear_sequence();
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_default();
    test_field_extremes();
    test_window_limits();
    test_short_sequence();
    test_window_change();
    test_random_streams();

    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d sample words over %0d window size writes.",
             items_sent, window_writes);
    $display("Checked %0d result words: %0d field mismatches, %0d unexpected.",
             results_checked, mismatch_count, unexpected_count);
    if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
